[rtl/ctw_pkg.sv]
package ctw_pkg;

   localparam int CSR_ADDR_W = 3;

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] RESET_ATTR     = 8'h0F;

   localparam logic [CSR_ADDR_W-3:0] REG_TEXT_ATTR = '0;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic [10:0] cursor_pos;
      logic        scrolled;
   } rsp_type;

endpackage

[rtl/ctw_screen_ram.sv]
module ctw_screen_ram import ctw_pkg::*; #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [15:0]       wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [15:0]       rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ctw_csr_regs.sv]
module ctw_csr_regs import ctw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output logic [7:0]            text_attr
);

   logic [7:0] attr_ff;
   logic [7:0] attr_in;
   logic       hit;

   // word index only, byte lanes ignored
   assign hit = (paddr[CSR_ADDR_W-1:2] == REG_TEXT_ATTR);

   always_comb begin
      attr_in = attr_ff;
      if (psel && penable && pwrite && hit) begin
         attr_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= RESET_ATTR;
      end else begin
         attr_ff <= attr_in;
      end
   end

   assign prdata    = hit ? {24'd0, attr_ff} : 32'd0;
   assign pready    = 1'b1;
   assign text_attr = attr_ff;

endmodule

[rtl/text_console_writer_unit.sv]
// Text console engine: a COLUMNS x ROWS screen of 16-bit cells (attribute in the upper byte,
// character in the lower) held in one single-port-write, one-read synchronous RAM, plus a
// cursor. Each request gives exactly one response. Put, read and unused opcodes are accepted,
// then executed against the RAM, whose read data arrives in the next cycle. A clear sweeps
// the RAM one cell per cycle. A put that runs past the last cell scrolls: the lower rows are
// copied one row up, one cell per cycle, and the bottom row blanked. After reset the block
// blanks the RAM in a clearing pass and holds req_stall high meanwhile; register writes are
// taken throughout. A finished response waits in the output register while the next request
// is accepted.
module text_console_writer_unit import ctw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(CELLS + 1);
   localparam int COLW  = $clog2(COLUMNS);
   localparam logic [CW-1:0]   LAST_CELL = CW'(CELLS - 1);
   localparam logic [CW-1:0]   SCROLL_LIM = CW'(CELLS - COLUMNS);
   localparam logic [CW-1:0]   CELLS_C = CW'(CELLS);
   localparam logic [CW-1:0]   COLS_C = CW'(COLUMNS);
   localparam logic [COLW-1:0] LAST_COL = COLW'(COLUMNS - 1);

   typedef enum logic [5:0] {
      ST_INIT   = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_EXEC   = 6'b000100,
      ST_SCROLL = 6'b001000,
      ST_BLANK  = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   state_type     state_ff, state_in;
   req_type       item_ff, item_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic [COLW-1:0] col_ff, col_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] dst_ff, dst_in;
   rsp_type       res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [15:0]   wr_data, rd_data;
   logic [7:0]    text_attr;
   logic [15:0]   blank;
   logic          out_free;
   logic          load_out;
   rsp_type       out_val;
   logic [CW-1:0] cur_n;
   logic [COLW-1:0] col_n;
   logic [CW-1:0] src;

   ctw_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .text_attr (text_attr)
   );

   ctw_screen_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign blank    = {text_attr, CHAR_SPACE};
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign src      = ptr_ff + COLS_C;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      cur_in       = cur_ff;
      col_in       = col_ff;
      ptr_in       = ptr_ff;
      pend_in      = 1'b0;
      dst_in       = dst_ff;
      res_in       = res_ff;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff[AW-1:0];
      wr_data      = blank;
      rd_addr      = AW'(req_data.cell_index);
      load_out     = 1'b0;
      out_val      = res_ff;
      cur_n        = cur_ff;
      col_n        = col_ff;
      req_stall    = (state_ff != ST_IDLE);

      case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_data = {RESET_ATTR, CHAR_SPACE};
            ptr_in  = ptr_ff + 1'b1;
            if (ptr_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_in.read_data = 16'd0;
            res_in.scrolled  = 1'b0;
            case (item_ff.opcode)
               OP_PUT: begin
                  case (item_ff.char_code)
                     CHAR_NEWLINE: begin
                        cur_n = cur_ff + (COLS_C - CW'(col_ff));
                        col_n = '0;
                     end
                     CHAR_BACKSPACE: begin
                        if (cur_ff != '0) begin
                           cur_n   = cur_ff - 1'b1;
                           col_n   = (col_ff == '0) ? LAST_COL : col_ff - 1'b1;
                           wr_en   = 1'b1;
                           wr_addr = cur_n[AW-1:0];
                        end
                     end
                     default: begin
                        wr_en   = 1'b1;
                        wr_addr = cur_ff[AW-1:0];
                        wr_data = {text_attr, item_ff.char_code};
                        cur_n   = cur_ff + 1'b1;
                        col_n   = (col_ff == LAST_COL) ? '0 : col_ff + 1'b1;
                     end
                  endcase
                  col_in = col_n;
                  if (cur_n >= CELLS_C) begin
                     cur_in          = cur_n - COLS_C;
                     res_in.scrolled = 1'b1;
                     ptr_in          = '0;
                     state_in        = ST_SCROLL;
                  end else begin
                     cur_in = cur_n;
                  end
               end
               OP_READ: begin
                  if (32'(item_ff.cell_index) < 32'(CELLS)) begin
                     res_in.read_data = rd_data;
                  end
               end
               OP_CLEAR: begin
                  cur_in   = '0;
                  col_in   = '0;
                  ptr_in   = '0;
                  state_in = ST_BLANK;
               end
               default: begin
               end
            endcase
            res_in.cursor_pos = 11'(cur_in);
            if (state_in == ST_EXEC) begin
               out_val = res_in;
               if (out_free) begin
                  load_out = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SCROLL: begin
            // read a row below, write it back one row up on the next cycle
            rd_addr = src[AW-1:0];
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = dst_ff;
               wr_data = rd_data;
            end
            if (ptr_ff != SCROLL_LIM) begin
               pend_in = 1'b1;
               dst_in  = ptr_ff[AW-1:0];
               ptr_in  = ptr_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = ST_BLANK;
            end
         end
         ST_BLANK: begin
            wr_en  = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == LAST_CELL) begin
               if (out_free) begin
                  load_out = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = out_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cur_ff       <= '0;
         col_ff       <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         col_ff       <= col_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      dst_ff      <= dst_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
